// ===== rtl/gsd_pkg.sv =====
package gsd_pkg;

    // Datapath widths of the vectoring CORDIC.
    localparam int XY_W = 28;
    localparam int Z_W  = 26;

    // Angles in 1/65536 degree.
    localparam logic signed [Z_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [27:0]    DEG180 = 28'sd11796480;
    localparam logic signed [27:0]    DEG360 = 28'sd23592960;

    // Gain removal and policy constants.
    localparam logic [15:0] GAIN_INV     = 16'd39797;
    localparam logic [26:0] REACH_LIMIT  = 27'd39321;
    localparam logic [15:0] CLEAR_LIMIT  = 16'd384;
    localparam logic [8:0]  LIN_OBST     = 9'd77;
    localparam logic [8:0]  LIN_MIN      = 9'd102;
    localparam logic [8:0]  LIN_MAX      = 9'd461;
    localparam logic signed [12:0] TURN_OBST = 13'sd2880;
    localparam logic signed [12:0] TURN_MAX  = 13'sd3840;

    // Register indexes.
    localparam logic REG_GOAL_X = 1'b0;
    localparam logic REG_GOAL_Z = 1'b1;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/goal_seeking_drive_policy_unit.sv =====
// Go-to-goal drive policy. Each request carries the robot position, heading and
// obstacle clearance; the block returns forward speed, turn rate and a reached flag
// toward the goal held in two registers. It accepts one request per clock cycle while
// the output is not stalled, and each result passes CORDIC_STAGES + 3 registers: one
// entry register with the quadrant pre-rotation, one register per CORDIC
// micro-rotation, one for the gain multiply and heading wrap, and the output
// register. A stall at the output holds the whole pipeline, so tready follows the
// output side.
module goal_seeking_drive_policy_unit
    import gsd_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: pos_x[15:0], pos_z[31:16], heading[47:32], clearance[63:48].
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: linear_speed[8:0], turn_rate[21:9], zero fill.
    output logic [23:0] m_tdata,
    // Fields from bit 0: goal_reached[0].
    output logic        m_tuser
);

    logic signed [15:0] goal_x_reg;
    logic signed [15:0] goal_z_reg;
    logic               en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= 16'sd1024;
            goal_z_reg <= -16'sd512;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_GOAL_X: goal_x_reg <= signed'(cfg_data);
                REG_GOAL_Z: goal_z_reg <= signed'(cfg_data);
                default:    ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being taken.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Goal offset and quadrant pre-rotation for a backward pointing vector.
    logic signed [16:0]     dx;
    logic signed [16:0]     dz;
    logic signed [XY_W-1:0] vx;
    logic signed [XY_W-1:0] vy;
    logic signed [XY_W-1:0] px;
    logic signed [XY_W-1:0] py;
    logic signed [Z_W-1:0]  pz;

    always_comb
    begin
        dx = 17'(goal_x_reg) - 17'(signed'(s_tdata[15:0]));
        dz = 17'(goal_z_reg) - 17'(signed'(s_tdata[31:16]));
        vx = XY_W'(dz) <<< 8;
        vy = XY_W'(dx) <<< 8;
        px = vx;
        py = vy;
        pz = '0;
        if (vx[XY_W-1])
        begin
            if (!vy[XY_W-1])
            begin
                px = vy;
                py = -vx;
                pz = DEG90;
            end
            else
            begin
                px = -vy;
                py = vx;
                pz = -DEG90;
            end
        end
    end

    logic                   c_valid;
    logic signed [XY_W-1:0] c_x;
    logic signed [Z_W-1:0]  c_z;
    logic [31:0]            c_side;

    gsd_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (32)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_in      (px),
        .y_in      (py),
        .z_in      (pz),
        .side_in   (s_tdata[63:32]),
        .out_valid (c_valid),
        .x_out     (c_x),
        .z_out     (c_z),
        .side_out  (c_side)
    );

    // Gain multiply and heading error wrap.
    logic                vld_m_reg;
    logic [42:0]         prod_reg;
    logic signed [27:0]  err_reg;
    logic [15:0]         clr_reg;
    logic [26:0]         mag;
    logic signed [27:0]  err_raw;
    logic signed [27:0]  err_wrap;

    always_comb
    begin
        mag      = c_x[XY_W-1] ? '0 : c_x[26:0];
        err_raw  = 28'(c_z) - (28'(signed'(c_side[15:0])) <<< 10);
        err_wrap = err_raw;
        if (err_raw > DEG180 + DEG360)
        begin
            err_wrap = err_raw - DEG360 - DEG360;
        end
        else if (err_raw > DEG180)
        begin
            err_wrap = err_raw - DEG360;
        end
        else if (err_raw < -DEG180 - DEG360)
        begin
            err_wrap = err_raw + DEG360 + DEG360;
        end
        else if (err_raw < -DEG180)
        begin
            err_wrap = err_raw + DEG360;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_m_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 43'(mag) * 43'(GAIN_INV);
            err_reg  <= err_wrap;
            clr_reg  <= c_side[31:16];
        end
    end

    // Policy selection and clamping.
    logic [26:0]        goal_dist;
    logic [26:0]        lin_sum;
    logic [11:0]        lin_n;
    logic [27:0]        lin_prod;
    logic [8:0]         lin_q;
    logic [8:0]         lin_next;
    logic signed [27:0] turn_full;
    logic signed [12:0] turn_next;
    logic               reached_next;

    always_comb
    begin
        goal_dist = 27'((prod_reg + 43'd32768) >> 16);
        lin_sum  = goal_dist + 27'd160;
        lin_n    = 12'(lin_sum >> 6);
        lin_prod = 28'(lin_n) * 28'd13108;
        lin_q    = 9'(lin_prod >> 16);
        turn_full = ((err_reg <<< 1) + err_reg + 28'sd1024) >>> 11;
        reached_next = (goal_dist <= REACH_LIMIT);
        if (reached_next)
        begin
            lin_next  = '0;
            turn_next = '0;
        end
        else if (clr_reg < CLEAR_LIMIT)
        begin
            lin_next  = LIN_OBST;
            turn_next = TURN_OBST;
        end
        else
        begin
            if (lin_sum >= 27'd147840)
            begin
                lin_next = LIN_MAX;
            end
            else if (lin_q < LIN_MIN)
            begin
                lin_next = LIN_MIN;
            end
            else
            begin
                lin_next = lin_q;
            end
            if (turn_full > 28'(TURN_MAX))
            begin
                turn_next = TURN_MAX;
            end
            else if (turn_full < -28'(TURN_MAX))
            begin
                turn_next = -TURN_MAX;
            end
            else
            begin
                turn_next = 13'(turn_full);
            end
        end
    end

    logic        vld_o_reg;
    logic [8:0]  lin_reg;
    logic [12:0] turn_reg;
    logic        reached_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_o_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg     <= lin_next;
            turn_reg    <= turn_next;
            reached_reg <= reached_next;
        end
    end

    assign m_tvalid = vld_o_reg;
    assign m_tdata  = {2'b00, turn_reg, lin_reg};
    assign m_tuser  = reached_reg;

    // A reached goal always commands a full stop.
    a_reached_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("reached result with nonzero command");

    // Speed stays within the command range.
    a_lin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[8:0] <= LIN_MAX)
        else $error("linear speed out of range");

    // Turn rate stays within the clamp.
    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> signed'(m_tdata[21:9]) <= TURN_MAX
                  && signed'(m_tdata[21:9]) >= -TURN_MAX)
        else $error("turn rate out of range");

    // A stalled result holds while the pipeline is frozen.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

// ===== rtl/gsd_cordic.sv =====
module gsd_cordic
    import gsd_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [Z_W-1:0]  z_out,
    output logic [SIDE_W-1:0]      side_out
);

    logic                   vld_reg  [0:STAGES];
    logic signed [XY_W-1:0] x_reg    [0:STAGES];
    logic signed [XY_W-1:0] y_reg    [0:STAGES];
    logic signed [Z_W-1:0]  z_reg    [0:STAGES];
    logic [SIDE_W-1:0]      side_reg [0:STAGES];

    // Entry register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_in;
            y_reg[0]    <= y_in;
            z_reg[0]    <= z_in;
            side_reg[0] <= side_in;
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  ang;

        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;
        assign ang = Z_W'(signed'({1'b0, atan_lut(5'(i))}));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (!y_reg[i][XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign x_out     = x_reg[STAGES];
    assign z_out     = z_reg[STAGES];
    assign side_out  = side_reg[STAGES];

endmodule

// ===== tb/sv/tb.sv =====
module tb
    import gsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 16 + 3;
    localparam int WATCHDOG  = 2000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [8:0]         linear_speed;
        logic signed [12:0] turn_rate;
        logic               goal_reached;
    } drive_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_en;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // Goal registers as the block should hold them.
    logic signed [15:0] goal_x_q;
    logic signed [15:0] goal_z_q;

    drive_cmd_t cmd_queue[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned requests_sent;
    int unsigned idle_cycles = 0;
    bit          stall_enable;

    goal_seeking_drive_policy_unit #(.CORDIC_STAGES(16)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_en   (cfg_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Arithmetic shift right, rounding toward minus infinity.
    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(input int i);
        longint t [0:15] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    // Expected drive command for one request under the current goal.
    function automatic drive_cmd_t compute_drive_cmd(input logic signed [15:0] px,
        input logic signed [15:0] pz, input logic signed [15:0] hd, input logic [15:0] clr);
        longint x, y, z, t, xs, ys, goal_dist, lin, turn, err;
        drive_cmd_t c;
        x = (longint'(goal_z_q) - longint'(pz)) * 256;
        y = (longint'(goal_x_q) - longint'(px)) * 256;
        z = 0;
        // Backward vectors are pre-rotated into the right half plane.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 5898240;
            end
            else
            begin
                x = -y;
                y = t;
                z = -5898240;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_step(i);
            end
        end
        if (x < 0)
            x = 0;
        goal_dist = (x * 39797 + 32768) >>> 16;
        c = '0;
        if (goal_dist * 5 < 196608)
        begin
            c.goal_reached = 1'b1;
            return c;
        end
        if (clr < 16'd384)
        begin
            lin = 77;
            turn = 2880;
        end
        else
        begin
            lin = (goal_dist + 160) / 320;
            if (lin < 102)
                lin = 102;
            if (lin > 461)
                lin = 461;
            err = z - longint'(hd) * 1024;
            while (err > 11796480)
                err -= 23592960;
            while (err < -11796480)
                err += 23592960;
            turn = asr(err * 3 + 1024, 11);
            if (turn > 3840)
                turn = 3840;
            if (turn < -3840)
                turn = -3840;
        end
        c.linear_speed = lin[8:0];
        c.turn_rate = turn[12:0];
        return c;
    endfunction

    // Send one request after a random gap and record its expected command.
    task automatic send_request(input logic [15:0] px, input logic [15:0] pz,
        input logic [15:0] hd, input logic [15:0] clr);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {clr, hd, pz, px};
        cmd_queue.push_back(compute_drive_cmd(px, pz, hd, clr));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Write one goal register while the block is idle.
    task automatic write_goal(input logic idx, input logic [15:0] v);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_en <= 1'b0;
        if (idx == REG_GOAL_X)
            goal_x_q = v;
        else
            goal_z_q = v;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (cmd_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Random goal-relative offset: mostly near the goal, sometimes anywhere.
    function automatic logic [15:0] near(input logic signed [15:0] g);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return g + 16'($signed($urandom_range(0, 400)) - 200);
            default: return g + 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [15:0] rand_clearance();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 383));
            1: return 16'($urandom_range(380, 390));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed;
        // Robot exactly on the goal, and just inside and outside the reach radius.
        send_request(goal_x_q, goal_z_q, 16'h0000, 16'hFFFF);
        send_request(goal_x_q + 16'd153, goal_z_q, 16'h0000, 16'hFFFF);
        send_request(goal_x_q + 16'd154, goal_z_q, 16'h0000, 16'hFFFF);
        // Reached goal wins over a close obstacle.
        send_request(goal_x_q, goal_z_q + 16'd10, 16'h1234, 16'h0000);
        // Obstacle threshold on both sides.
        send_request(goal_x_q + 16'd2000, goal_z_q, 16'h0000, 16'd383);
        send_request(goal_x_q + 16'd2000, goal_z_q, 16'h0000, 16'd384);
        // Bearing ahead, straight behind, to one side and in both rear quadrants.
        send_request(goal_x_q, goal_z_q - 16'd3000, 16'h0000, 16'hFFFF);
        send_request(goal_x_q, goal_z_q + 16'd3000, 16'h0000, 16'hFFFF);
        send_request(goal_x_q - 16'd3000, goal_z_q + 16'd3000, 16'h0000, 16'hFFFF);
        send_request(goal_x_q + 16'd3000, goal_z_q + 16'd3000, 16'h0000, 16'hFFFF);
        send_request(goal_x_q - 16'd3000, goal_z_q, 16'h0000, 16'hFFFF);
        // Heading extremes and a heading error near half a turn.
        send_request(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_request(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_request(goal_x_q, goal_z_q - 16'd3000, 16'sd11520, 16'hFFFF);
        send_request(goal_x_q, goal_z_q - 16'd3000, -16'sd11520, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000);
        // Speed: a short distance and a long one that hits the upper clamp.
        send_request(goal_x_q + 16'd300, goal_z_q, 16'h0000, 16'hFFFF);
        send_request(goal_x_q - 16'd30000, goal_z_q - 16'd30000, 16'h0000, 16'hFFFF);
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_request(near(goal_x_q), near(goal_z_q), 16'($urandom), rand_clearance());
        drain();
    endtask

    task automatic test_goal_settings;
        write_goal(REG_GOAL_X, 16'h8000);
        write_goal(REG_GOAL_Z, 16'h7FFF);
        test_random(60);
        write_goal(REG_GOAL_X, 16'h7FFF);
        write_goal(REG_GOAL_Z, 16'h8000);
        test_random(60);
        write_goal(REG_GOAL_X, 16'h0000);
        write_goal(REG_GOAL_Z, 16'h0000);
        test_directed();
        for (int k = 0; k < 4; k++)
        begin
            write_goal(REG_GOAL_X, 16'($urandom));
            write_goal(REG_GOAL_Z, 16'($urandom));
            test_random(60);
        end
    endtask

    // Output side: random stall before each result while stalls are enabled, checked against the oldest entry.
    initial
    begin
        int wait_cycles;
        drive_cmd_t got;
        drive_cmd_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = stall_enable ? $urandom_range(0, 11) : 0;
            if (wait_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.linear_speed = m_tdata[8:0];
            got.turn_rate = m_tdata[21:9];
            got.goal_reached = m_tuser;
            results_seen++;
            if (cmd_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = cmd_queue.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_en = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        goal_x_q = 16'sd1024;
        goal_z_q = -16'sd512;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        stall_enable = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(60);
        test_goal_settings();
        // A stretch with no stalls on the output side.
        stall_enable = 1'b0;
        test_random(40);
        drain();

        $display("Covered %0d requests and %0d results over several goal settings.",
            requests_sent, results_seen);
        if (mismatches == 0 && cmd_queue.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
